// ----- rtl/core/ssfms_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssfms_pkg
// Shared constants and controller/datapath handshake types.
// ---------------------------------------------------------------------------
package ssfms_pkg;

  localparam int DEF_MAX_ITEMS = 1024;
  localparam int VAL_W         = 32;
  localparam int POS_W         = 11;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;
    logic srch_rd;
    logic srch_cmp;
    logic fin_rd;
    logic shift_prep;
    logic shift_step;
    logic insert;
    logic set_drop;
    logic emit;
  } ssfms_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_query;
    logic full;
    logic lo_lt_hi;
    logic sp_gt_lo;
    logic out_free;
  } ssfms_sts_t;

endpackage

// ----- rtl/core/ssfms_req_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssfms_req_if
// Input channel: load or query beats.
// ---------------------------------------------------------------------------
interface ssfms_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] item_value;
  logic        first_of_set;

  modport source (output valid, kind, item_value, first_of_set, input ready);
  modport sink   (input valid, kind, item_value, first_of_set, output ready);
endinterface

// ----- rtl/core/ssfms_rsp_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssfms_rsp_if
// Output channel: query result beats.
// ---------------------------------------------------------------------------
interface ssfms_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [10:0] position;
  logic        overflow;

  modport source (output valid, found, position, overflow, input ready);
  modport sink   (input valid, found, position, overflow, output ready);
endinterface

// ----- rtl/core/ssfms_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssfms_ctrl
// Sequencer for binary search, shift-up insertion and result hand-off.
// ---------------------------------------------------------------------------
module ssfms_ctrl
  import ssfms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_fire,
  output logic       idle,
  input  ssfms_sts_t sts,
  output ssfms_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHK    = 4'd1;
  localparam logic [3:0] ST_LOOP   = 4'd2;
  localparam logic [3:0] ST_SRD    = 4'd3;
  localparam logic [3:0] ST_SCMP   = 4'd4;
  localparam logic [3:0] ST_FRD    = 4'd5;
  localparam logic [3:0] ST_SHIFT  = 4'd6;
  localparam logic [3:0] ST_DRAIN  = 4'd7;
  localparam logic [3:0] ST_INSERT = 4'd8;
  localparam logic [3:0] ST_RESULT = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign idle = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          cmd.start  = 1'b1;
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (!sts.is_query && sts.full) begin
          cmd.set_drop = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (sts.lo_lt_hi) begin
          state_next = ST_SRD;
        end else if (sts.is_query) begin
          state_next = ST_FRD;
        end else begin
          cmd.shift_prep = 1'b1;
          state_next     = ST_SHIFT;
        end
      end
      ST_SRD: begin
        cmd.srch_rd = 1'b1;
        state_next  = ST_SCMP;
      end
      ST_SCMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = ST_LOOP;
      end
      ST_FRD: begin
        cmd.fin_rd = 1'b1;
        state_next = ST_RESULT;
      end
      ST_SHIFT: begin
        if (sts.sp_gt_lo) begin
          cmd.shift_step = 1'b1;
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == ST_IDLE)
    else $error("emit not followed by idle");
  a_start_chk: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state == ST_CHK)
    else $error("accepted beat did not start work");
  a_insert_load: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !sts.is_query)
    else $error("insert during query");
`endif

endmodule

// ----- rtl/core/ssfms_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssfms_dp
// Sorted value memory, search bounds, shift pointer and result register.
// ---------------------------------------------------------------------------
module ssfms_dp
  import ssfms_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_kind,
  input  logic [VAL_W-1:0] req_value,
  input  logic             req_first,
  input  ssfms_cmd_t       cmd,
  output ssfms_sts_t       sts,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             out_found,
  output logic [POS_W-1:0] out_position,
  output logic             out_overflow
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

  logic [VAL_W-1:0] mem [MAX_ITEMS];
  logic [VAL_W-1:0] rdata;
  logic [VAL_W-1:0] key;
  logic             is_query;
  logic [CW-1:0]    count;
  logic             dropped;
  logic [CW-1:0]    lo;
  logic [CW-1:0]    hi;
  logic [CW-1:0]    sp;
  logic             wr_pend;
  logic [AW-1:0]    wr_addr;

  logic [CW-1:0] mid;
  logic [CW-1:0] sp_m1;
  logic          go_right;
  logic          hit;
  logic [PW-1:0] pos_wide;

  // search midpoint and compare
  assign mid      = lo + ((hi - lo) >> 1);
  assign sp_m1    = sp - CW'(1);
  assign go_right = is_query ? ($signed(rdata) <  $signed(key))
                             : ($signed(rdata) <= $signed(key));
  assign hit      = (lo < count) && (rdata == key);
  assign pos_wide = PW'(lo) + PW'(1);

  assign sts.is_query = is_query;
  assign sts.full     = (count >= MAX_C);
  assign sts.lo_lt_hi = (lo < hi);
  assign sts.sp_gt_lo = (sp > lo);
  assign sts.out_free = !out_valid || out_ready;

  // memory read and write ports
  always_ff @(posedge clk) begin
    if (cmd.srch_rd) begin
      rdata <= mem[mid[AW-1:0]];
    end else if (cmd.fin_rd) begin
      rdata <= mem[lo[AW-1:0]];
    end else if (cmd.shift_step) begin
      rdata <= mem[sp_m1[AW-1:0]];
    end
    if (wr_pend) begin
      mem[wr_addr] <= rdata;
    end else if (cmd.insert) begin
      mem[lo[AW-1:0]] <= key;
    end
  end

  // beat capture, bounds and shift pointer
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key      <= req_value;
      is_query <= (req_kind == KIND_QUERY);
      lo       <= '0;
      hi       <= (req_kind == KIND_LOAD && req_first) ? '0 : count;
    end else if (cmd.srch_cmp) begin
      if (go_right) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.shift_prep) begin
      sp <= count;
    end else if (cmd.shift_step) begin
      sp <= sp_m1;
    end
    wr_addr <= sp[AW-1:0];
  end

  // set size, overflow flag and pending shift write
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.shift_step;
      if (cmd.start && req_kind == KIND_LOAD && req_first) begin
        count   <= '0;
        dropped <= 1'b0;
      end else if (cmd.set_drop) begin
        dropped <= 1'b1;
      end else if (cmd.insert) begin
        count <= count + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found    <= hit;
      out_position <= hit ? pos_wide[POS_W-1:0] : '0;
      out_overflow <= dropped;
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_C)
    else $error("set size above capacity");
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_rd |-> (lo < hi) && (hi <= count))
    else $error("search bounds broken");
  a_no_wr_clash: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !wr_pend)
    else $error("insert collides with shift write");
`endif

endmodule

// ----- rtl/core/sorted_set_first_match_search.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_set_first_match_search
// Sorted set kept by insertion, looked up by lower-bound binary search.
// ---------------------------------------------------------------------------
//   port  dir  beat contents
//   req   in   kind, item_value, first_of_set
//   rsp   out  found, position, overflow (query beats only)
//
// query: each search step is a memory read then a compare, on the single read
//   port; a final read at the lower bound then gives the result.
// load: a search for the insert point, then each value above it is moved up one
//   place and the value is written; a load into a full set is dropped before any search.
// reset clears set size and overflow flag; memory contents are not cleared.
// a query result waits in the output register; a new beat is taken meanwhile,
//   a later query holds in its last state until that register frees up.
module sorted_set_first_match_search
  import ssfms_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic   clk,
  input  logic   rst,
  ssfms_req_if.sink   req,
  ssfms_rsp_if.source rsp
);

  ssfms_cmd_t cmd;
  ssfms_sts_t sts;
  logic       idle;
  logic       req_fire;

  assign req.ready = idle;
  assign req_fire  = req.valid && idle;

  // sequencer
  ssfms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_fire (req_fire),
    .idle     (idle),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and compare
  ssfms_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_kind     (req.kind),
    .req_value    (req.item_value),
    .req_first    (req.first_of_set),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .out_found    (rsp.found),
    .out_position (rsp.position),
    .out_overflow (rsp.overflow)
  );

endmodule
